### hw/rtl/tlrs_pkg.sv
// Shared types and constants for the text line row segmenter.
`timescale 1ns / 1ps

package tlrs_pkg;

   localparam int PIXEL_BITS = 8;
   localparam logic [PIXEL_BITS-1:0] WHITE_THRESHOLD_RESET = 8'd230;

   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_ADDR_BITS = 5;

   typedef enum logic [2:0] {
      REG_WINDOW_LEFT     = 3'd0,
      REG_WINDOW_RIGHT    = 3'd1,
      REG_WINDOW_TOP      = 3'd2,
      REG_WINDOW_BOTTOM   = 3'd3,
      REG_WHITE_THRESHOLD = 3'd4
   } reg_index_type;

   typedef enum logic {
      KIND_SEGMENT = 1'b0,
      KIND_SUMMARY = 1'b1
   } kind_type;

   // What a queued job asks the back end to send.
   typedef struct packed {
      logic seg;   // one segment record
      logic sum;   // frame summary, always sent last
   } job_flags_type;

endpackage

### hw/rtl/text_line_row_segmenter_unit.sv
// Top level of the text line row segmenter: register file, front end, queue, back end.
`timescale 1ns / 1ps

// Text line row segmenter.
// req_ carries one pixel per request: channels and position in tdata, end of row
// in tuser, end of frame in tlast. A row inside the window whose pixels inside the
// column window are all brighter than the white threshold on every channel counts
// as white; each run of non-white rows is reported on rsp_ as a segment record,
// and every end-of-frame request adds a summary with the frame's line count.
// rsp_tlast marks the final response of a request.
// Throughput: one request per clock while the queue has room. The front end judges
// each pixel in the cycle it is taken and posts at most one job per request to a
// QUEUE_DEPTH-entry queue; the back end sends one response per clock while
// rsp_tready is high; an end-of-frame request that closes a run yields a segment
// record and then a summary. A job passes the queue and the back end's job register.
// When the receiver stalls, the back end holds its response and the queue fills;
// req_tready drops only once the queue is full. Pixels that post no job still need
// a free queue slot to be taken.
// Reset (synchronous) restores the window to the full frame, the threshold to its
// default, clears run tracking and empties the queue. Registers sit at byte addresses
// 0x00..0x10 on csr_; the user must write them while the block is idle (not enforced).

module text_line_row_segmenter_unit #(
   parameter int COORD_BITS  = 12,
   parameter int QUEUE_DEPTH = 4
) (
   input  logic                               clock,
   input  logic                               reset,
   // requests: pixels
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // red, green, blue, col, row (lowest bit first), zero padded to bytes
   input  logic [((24+2*COORD_BITS+7)/8)*8-1:0] req_tdata,
   input  logic                               req_tuser,   // row_end
   input  logic                               req_tlast,   // frame_end
   // responses
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // line_index, start_row, end_row, line_total (lowest bit first), zero padded
   output logic [((4*COORD_BITS+7)/8)*8-1:0]  rsp_tdata,
   output logic                               rsp_tuser,   // kind
   output logic                               rsp_tlast,   // last
   // register port
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [tlrs_pkg::CSR_ADDR_BITS-1:0] csr_paddr,
   input  logic [tlrs_pkg::CSR_DATA_BITS-1:0] csr_pwdata,
   output logic [tlrs_pkg::CSR_DATA_BITS-1:0] csr_prdata,
   output logic                               csr_pready
);
   import tlrs_pkg::*;

   localparam int JOB_BITS = 2 + 4 * COORD_BITS;
   localparam logic [COORD_BITS:0] WINDOW_FULL = {1'b1, {COORD_BITS{1'b0}}};
   localparam int COL_LSB = 3 * PIXEL_BITS;
   localparam int ROW_LSB = COL_LSB + COORD_BITS;

   // Register file
   logic [COORD_BITS:0]   window_left_ff, window_right_ff;
   logic [COORD_BITS:0]   window_top_ff, window_bottom_ff;
   logic [PIXEL_BITS-1:0] white_threshold_ff;
   logic                  csr_write;
   reg_index_type         reg_index;

   assign csr_pready = 1'b1;
   assign reg_index  = reg_index_type'(csr_paddr[4:2]);
   assign csr_write  = csr_psel & csr_penable & csr_pwrite & csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         window_left_ff     <= '0;
         window_right_ff    <= WINDOW_FULL;
         window_top_ff      <= '0;
         window_bottom_ff   <= WINDOW_FULL;
         white_threshold_ff <= WHITE_THRESHOLD_RESET;
      end else if (csr_write) begin
         case (reg_index)
            REG_WINDOW_LEFT:     window_left_ff     <= csr_pwdata[COORD_BITS:0];
            REG_WINDOW_RIGHT:    window_right_ff    <= csr_pwdata[COORD_BITS:0];
            REG_WINDOW_TOP:      window_top_ff      <= csr_pwdata[COORD_BITS:0];
            REG_WINDOW_BOTTOM:   window_bottom_ff   <= csr_pwdata[COORD_BITS:0];
            REG_WHITE_THRESHOLD: white_threshold_ff <= csr_pwdata[PIXEL_BITS-1:0];
            default: ;   // drop writes past the last register
         endcase
      end
   end

   always_comb begin
      case (reg_index)
         REG_WINDOW_LEFT:     csr_prdata = CSR_DATA_BITS'(window_left_ff);
         REG_WINDOW_RIGHT:    csr_prdata = CSR_DATA_BITS'(window_right_ff);
         REG_WINDOW_TOP:      csr_prdata = CSR_DATA_BITS'(window_top_ff);
         REG_WINDOW_BOTTOM:   csr_prdata = CSR_DATA_BITS'(window_bottom_ff);
         REG_WHITE_THRESHOLD: csr_prdata = CSR_DATA_BITS'(white_threshold_ff);
         default:             csr_prdata = '0;
      endcase
   end

   // Front end: take a pixel whenever the queue has room
   logic                  pix_accept;
   logic                  job_push;
   job_flags_type         job_flags;
   logic [COORD_BITS-1:0] job_index, job_start, job_end, job_total;
   logic                  q_full, q_empty, q_pop;
   logic [JOB_BITS-1:0]   q_push_data, q_pop_data;

   assign req_tready = !q_full;
   assign pix_accept = req_tvalid & req_tready;

   tlrs_front #(
      .COORD_BITS(COORD_BITS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .pix_valid      (pix_accept),
      .red            (req_tdata[PIXEL_BITS-1:0]),
      .green          (req_tdata[2*PIXEL_BITS-1:PIXEL_BITS]),
      .blue           (req_tdata[3*PIXEL_BITS-1:2*PIXEL_BITS]),
      .col            (req_tdata[COL_LSB +: COORD_BITS]),
      .row            (req_tdata[ROW_LSB +: COORD_BITS]),
      .row_end        (req_tuser),
      .frame_end      (req_tlast),
      .window_left    (window_left_ff),
      .window_right   (window_right_ff),
      .window_top     (window_top_ff),
      .window_bottom  (window_bottom_ff),
      .white_threshold(white_threshold_ff),
      .job_push       (job_push),
      .job_flags      (job_flags),
      .job_index      (job_index),
      .job_start      (job_start),
      .job_end        (job_end),
      .job_total      (job_total)
   );

   // Job queue: lets the front end keep taking pixels while responses stall
   assign q_push_data = {job_total, job_end, job_start, job_index, job_flags};

   tlrs_queue #(
      .WIDTH(JOB_BITS),
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (job_push),
      .push_data(q_push_data),
      .full     (q_full),
      .pop      (q_pop),
      .pop_data (q_pop_data),
      .empty    (q_empty)
   );

   // Back end: one response per clock from the head job while rsp_tready is high
   kind_type rsp_kind;

   tlrs_back #(
      .COORD_BITS(COORD_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (!q_empty),
      .job_pop   (q_pop),
      .job_flags (job_flags_type'(q_pop_data[1:0])),
      .job_index (q_pop_data[2 +: COORD_BITS]),
      .job_start (q_pop_data[2 + COORD_BITS +: COORD_BITS]),
      .job_end   (q_pop_data[2 + 2*COORD_BITS +: COORD_BITS]),
      .job_total (q_pop_data[2 + 3*COORD_BITS +: COORD_BITS]),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_kind),
      .rsp_tlast (rsp_tlast)
   );

   assign rsp_tuser = rsp_kind;

endmodule

### hw/rtl/tlrs_front.sv
// Front end: pixel classification, row evaluation and run tracking.
`timescale 1ns / 1ps

module tlrs_front #(
   parameter int COORD_BITS = 12
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            pix_valid,
   input  logic [tlrs_pkg::PIXEL_BITS-1:0] red,
   input  logic [tlrs_pkg::PIXEL_BITS-1:0] green,
   input  logic [tlrs_pkg::PIXEL_BITS-1:0] blue,
   input  logic [COORD_BITS-1:0]           col,
   input  logic [COORD_BITS-1:0]           row,
   input  logic                            row_end,
   input  logic                            frame_end,
   input  logic [COORD_BITS:0]             window_left,
   input  logic [COORD_BITS:0]             window_right,
   input  logic [COORD_BITS:0]             window_top,
   input  logic [COORD_BITS:0]             window_bottom,
   input  logic [tlrs_pkg::PIXEL_BITS-1:0] white_threshold,
   output logic                            job_push,
   output tlrs_pkg::job_flags_type         job_flags,
   output logic [COORD_BITS-1:0]           job_index,
   output logic [COORD_BITS-1:0]           job_start,
   output logic [COORD_BITS-1:0]           job_end,
   output logic [COORD_BITS-1:0]           job_total
);
   import tlrs_pkg::*;

   localparam logic [COORD_BITS-1:0] COORD_MAX = {COORD_BITS{1'b1}};

   logic                  row_all_white_ff, row_all_white_in;
   logic                  prev_row_white_ff, prev_row_white_in;
   logic [COORD_BITS-1:0] run_start_ff, run_start_in;
   logic [COORD_BITS-1:0] segment_count_ff, segment_count_in;

   logic                  in_rows, in_cols, is_white, row_white, row_done, judged;
   logic                  close_by_row, open_run, prev_after, close_at_frame, seg;
   logic [COORD_BITS-1:0] start_after, count_sat, bottom_end;
   logic [COORD_BITS:0]   bottom_m1;

   always_comb begin
      in_rows  = ({1'b0, row} >= window_top) && ({1'b0, row} < window_bottom);
      in_cols  = ({1'b0, col} >= window_left) && ({1'b0, col} < window_right);
      is_white = (red > white_threshold) && (green > white_threshold) &&
                 (blue > white_threshold);
      row_white = row_all_white_ff && !(in_rows && in_cols && !is_white);
      row_done  = row_end | frame_end;
      judged    = row_done & in_rows;

      close_by_row   = judged & row_white & !prev_row_white_ff;
      open_run       = judged & !row_white & prev_row_white_ff;
      prev_after     = judged ? row_white : prev_row_white_ff;
      start_after    = open_run ? row : run_start_ff;
      close_at_frame = frame_end & !prev_after;
      seg            = close_by_row | close_at_frame;

      count_sat = (segment_count_ff == COORD_MAX) ? COORD_MAX : segment_count_ff + 1'b1;

      // Window bottom minus one, clamped to the coordinate range
      bottom_m1 = window_bottom - 1'b1;
      if (window_bottom == '0) begin
         bottom_end = '0;
      end else if (bottom_m1[COORD_BITS]) begin
         bottom_end = COORD_MAX;
      end else begin
         bottom_end = bottom_m1[COORD_BITS-1:0];
      end
   end

   always_comb begin
      job_flags.seg = seg;
      job_flags.sum = frame_end;
      job_push      = pix_valid & (seg | frame_end);
      job_index     = segment_count_ff;
      job_start     = start_after;
      job_end       = close_by_row ? row - 1'b1 : bottom_end;
      job_total     = seg ? count_sat : segment_count_ff;
   end

   always_comb begin
      row_all_white_in  = row_all_white_ff;
      prev_row_white_in = prev_row_white_ff;
      run_start_in      = run_start_ff;
      segment_count_in  = segment_count_ff;
      if (pix_valid) begin
         if (frame_end) begin
            row_all_white_in  = 1'b1;
            prev_row_white_in = 1'b1;
            run_start_in      = '0;
            segment_count_in  = '0;
         end else begin
            row_all_white_in  = row_done ? 1'b1 : row_white;
            prev_row_white_in = prev_after;
            run_start_in      = start_after;
            segment_count_in  = seg ? count_sat : segment_count_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_all_white_ff  <= 1'b1;
         prev_row_white_ff <= 1'b1;
         run_start_ff      <= '0;
         segment_count_ff  <= '0;
      end else begin
         row_all_white_ff  <= row_all_white_in;
         prev_row_white_ff <= prev_row_white_in;
         run_start_ff      <= run_start_in;
         segment_count_ff  <= segment_count_in;
      end
   end

endmodule

### hw/rtl/tlrs_queue.sv
// Small job queue between the front and back ends.
`timescale 1ns / 1ps

module tlrs_queue #(
   parameter int WIDTH = 50,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);
   import tlrs_pkg::*;

   localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    slots_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff, count_in;

   always_comb begin
      full     = (count_ff == CNT_BITS'(DEPTH));
      empty    = (count_ff == '0);
      pop_data = slots_ff[rd_ptr_ff];

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end

      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

`ifndef SYNTHESIS
   a_no_push_when_full : assert property (@(posedge clock) disable iff (reset)
      push |-> !full) else $error("queue written while full");

   a_no_pop_when_empty : assert property (@(posedge clock) disable iff (reset)
      pop |-> !empty) else $error("queue read while empty");

   a_count_bounded : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_BITS'(DEPTH)) else $error("queue fill count out of range");
`endif

endmodule

### hw/rtl/tlrs_back.sv
// Back end: expands queued jobs into segment and summary responses.
`timescale 1ns / 1ps

module tlrs_back #(
   parameter int COORD_BITS = 12
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             job_valid,
   output logic                             job_pop,
   input  tlrs_pkg::job_flags_type          job_flags,
   input  logic [COORD_BITS-1:0]            job_index,
   input  logic [COORD_BITS-1:0]            job_start,
   input  logic [COORD_BITS-1:0]            job_end,
   input  logic [COORD_BITS-1:0]            job_total,
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [((4*COORD_BITS+7)/8)*8-1:0] rsp_tdata,
   output tlrs_pkg::kind_type               rsp_tuser,
   output logic                             rsp_tlast
);
   import tlrs_pkg::*;

   localparam int OUT_DATA_BITS = ((4 * COORD_BITS + 7) / 8) * 8;

   logic                  busy_ff, busy_in;
   logic                  seg_sent_ff, seg_sent_in;
   job_flags_type         flags_ff;
   logic [COORD_BITS-1:0] index_ff, start_ff, end_ff, total_ff;

   logic show_seg, cur_last, done;

   always_comb begin
      show_seg = flags_ff.seg & !seg_sent_ff;
      cur_last = !(show_seg & flags_ff.sum);
      done     = busy_ff & rsp_tready & cur_last;
      job_pop  = job_valid & (!busy_ff | done);

      busy_in = busy_ff;
      if (job_pop) begin
         busy_in = 1'b1;
      end else if (done) begin
         busy_in = 1'b0;
      end

      seg_sent_in = seg_sent_ff;
      if (job_pop) begin
         seg_sent_in = 1'b0;
      end else if (busy_ff && rsp_tready && !cur_last) begin
         seg_sent_in = 1'b1;
      end
   end

   always_comb begin
      rsp_tvalid = busy_ff;
      rsp_tlast  = cur_last;
      if (show_seg) begin
         rsp_tuser = KIND_SEGMENT;
         rsp_tdata = OUT_DATA_BITS'({total_ff, end_ff, start_ff, index_ff});
      end else begin
         rsp_tuser = KIND_SUMMARY;
         rsp_tdata = OUT_DATA_BITS'({total_ff, {(3 * COORD_BITS){1'b0}}});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff     <= 1'b0;
         seg_sent_ff <= 1'b0;
      end else begin
         busy_ff     <= busy_in;
         seg_sent_ff <= seg_sent_in;
      end
   end

   always_ff @(posedge clock) begin
      if (job_pop) begin
         flags_ff <= job_flags;
         index_ff <= job_index;
         start_ff <= job_start;
         end_ff   <= job_end;
         total_ff <= job_total;
      end
   end

`ifndef SYNTHESIS
   a_job_not_empty : assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (flags_ff.seg || flags_ff.sum)) else $error("held job sends nothing");

   a_summary_follows : assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tready && !rsp_tlast) |=>
      (rsp_tvalid && rsp_tuser == KIND_SUMMARY))
      else $error("segment not followed by summary");
`endif

endmodule
